// ===== rtl/core/dad_pkg.sv =====
// Package for the date add-days core: widths, microcode format, program and calendar tables.
`default_nettype none

package dad_pkg;

   // Field widths of the item payloads
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int COUNT_W = 16;

   // Day-of-year values reach 366
   localparam int DOY_W  = 9;
   // Step counter and microcode word fields
   localparam int PC_W   = 4;
   localparam int ARG_W  = 3;
   localparam int UCODE_DEPTH = 16;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DOY_W-1:0]   DAYS_LEAP_YEAR   = 9'd366;
   localparam logic [DOY_W-1:0]   DAYS_COMMON_YEAR = 9'd365;
   localparam logic [YEAR_W-1:0]  CYCLE_400_LAST   = 14'd399;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_R400,
      OP_CLAMP,
      OP_DOY_ADD,
      OP_YEAR_FIRST,
      OP_YEAR_STEP,
      OP_SPLIT_INIT,
      OP_SPLIT_STEP,
      OP_OUT
   } op_type;

   // Sequencing conditions
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_REQ,
      COND_RSP,
      COND_I_LT_M,
      COND_X_LE_REM,
      COND_X_GT_LEN,
      COND_SPLIT
   } cond_type;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic [PC_W-1:0]      target;
      logic [ARG_W-1:0]     arg;
   } ucode_type;

   // Flags from the datapath that steer conditional jumps
   typedef struct packed {
      logic i_lt_m;
      logic x_le_rem;
      logic x_gt_len;
      logic split_go;
   } dp_flags_type;

   // Step addresses used as jump targets
   localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
   localparam logic [PC_W-1:0] STEP_R400_FIRST = 4'd1;
   localparam logic [PC_W-1:0] STEP_DOY_LOOP   = 4'd8;
   localparam logic [PC_W-1:0] STEP_YEAR_LOOP  = 4'd10;
   localparam logic [PC_W-1:0] STEP_SPLIT_INIT = 4'd11;
   localparam logic [PC_W-1:0] STEP_SPLIT_LOOP = 4'd12;

   // The program: one control word per step
   localparam ucode_type UCODE_ROM [UCODE_DEPTH] = '{
      '{OP_LOAD,       COND_REQ,      STEP_R400_FIRST, 3'd0},  // wait for an item
      '{OP_R400,       COND_NEXT,     STEP_IDLE,       3'd0},  // year mod 400, 12800
      '{OP_R400,       COND_NEXT,     STEP_IDLE,       3'd1},  // 6400
      '{OP_R400,       COND_NEXT,     STEP_IDLE,       3'd2},  // 3200
      '{OP_R400,       COND_NEXT,     STEP_IDLE,       3'd3},  // 1600
      '{OP_R400,       COND_NEXT,     STEP_IDLE,       3'd4},  // 800
      '{OP_R400,       COND_NEXT,     STEP_IDLE,       3'd5},  // 400
      '{OP_CLAMP,      COND_NEXT,     STEP_IDLE,       3'd0},  // clamp day
      '{OP_DOY_ADD,    COND_I_LT_M,   STEP_DOY_LOOP,   3'd0},  // day of year
      '{OP_YEAR_FIRST, COND_X_LE_REM, STEP_SPLIT_INIT, 3'd0},  // rest of start year
      '{OP_YEAR_STEP,  COND_X_GT_LEN, STEP_YEAR_LOOP,  3'd0},  // whole years
      '{OP_SPLIT_INIT, COND_NEXT,     STEP_IDLE,       3'd0},
      '{OP_SPLIT_STEP, COND_SPLIT,    STEP_SPLIT_LOOP, 3'd0},  // month and day
      '{OP_OUT,        COND_RSP,      STEP_IDLE,       3'd0},  // present result
      '{OP_NOP,        COND_JUMP,     STEP_IDLE,       3'd0},
      '{OP_NOP,        COND_JUMP,     STEP_IDLE,       3'd0}
   };

   // Subtrahends for the restoring mod-400 reduction
   function automatic logic [YEAR_W-1:0] r400_sub(input logic [ARG_W-1:0] arg);
      logic [YEAR_W-1:0] val;
      case (arg)
         3'd0:    val = 14'd12800;
         3'd1:    val = 14'd6400;
         3'd2:    val = 14'd3200;
         3'd3:    val = 14'd1600;
         3'd4:    val = 14'd800;
         3'd5:    val = 14'd400;
         default: val = 14'd0;
      endcase
      return val;
   endfunction

   // Month length, February follows the leap flag
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
                                                  input logic leap);
      logic [DAY_W-1:0] val;
      case (mon)
         4'd2:    val = leap ? 5'd29 : 5'd28;
         4'd4:    val = 5'd30;
         4'd6:    val = 5'd30;
         4'd9:    val = 5'd30;
         4'd11:   val = 5'd30;
         default: val = 5'd31;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dad_if.sv =====
// Valid/ready channel interfaces for request and response items.
`default_nettype none

interface dad_req_if import dad_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   start_day;
   logic [MONTH_W-1:0] start_month;
   logic [YEAR_W-1:0]  start_year;
   logic [COUNT_W-1:0] days_to_add;

   modport source (output valid, output start_day, output start_month,
                   output start_year, output days_to_add, input ready);
   modport sink   (input valid, input start_day, input start_month,
                   input start_year, input days_to_add, output ready);
endinterface

interface dad_rsp_if import dad_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   result_day;
   logic [MONTH_W-1:0] result_month;
   logic [YEAR_W-1:0]  result_year;

   modport source (output valid, output result_day, output result_month,
                   output result_year, input ready);
   modport sink   (input valid, input result_day, input result_month,
                   input result_year, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dad_seq.sv =====
// Microcode sequencer: step counter, program lookup and conditional jumps.
`default_nettype none

module dad_seq import dad_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_fire,
   input  wire logic          rsp_fire,
   input  wire dp_flags_type  flags,
   output ucode_type          uword
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic [PC_W-1:0] pc_inc;

   // Control word for the current step
   always_comb begin
      uword = UCODE_ROM[pc_ff];
   end

   // Next step
   always_comb begin
      pc_inc = pc_ff + 1'b1;
      case (uword.cond)
         COND_NEXT:     pc_in = pc_inc;
         COND_JUMP:     pc_in = uword.target;
         COND_REQ:      pc_in = req_fire ? uword.target : pc_ff;
         COND_RSP:      pc_in = rsp_fire ? uword.target : pc_ff;
         COND_I_LT_M:   pc_in = flags.i_lt_m   ? uword.target : pc_inc;
         COND_X_LE_REM: pc_in = flags.x_le_rem ? uword.target : pc_inc;
         COND_X_GT_LEN: pc_in = flags.x_gt_len ? uword.target : pc_inc;
         COND_SPLIT:    pc_in = flags.split_go ? uword.target : pc_inc;
         default:       pc_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // An accepted item starts the program
   ap_req_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> pc_ff == STEP_R400_FIRST)
      else $error("accepted item did not start the program");

   // A delivered result returns to idle
   ap_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> pc_ff == STEP_IDLE)
      else $error("sequencer did not return to idle after delivery");

   // A waiting result is not abandoned
   ap_out_hold: assert property (@(posedge clock) disable iff (reset)
      (uword.op == OP_OUT && !rsp_fire) |=> uword.op == OP_OUT)
      else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== rtl/core/dad_dp.sv =====
// Datapath: date registers, mod-400 year residue and the calendar arithmetic.
`default_nettype none

module dad_dp import dad_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ucode_type          uword,
   input  wire logic               req_fire,
   input  wire logic [DAY_W-1:0]   start_day,
   input  wire logic [MONTH_W-1:0] start_month,
   input  wire logic [YEAR_W-1:0]  start_year,
   input  wire logic [COUNT_W-1:0] days_to_add,
   output dp_flags_type            flags,
   output logic [DAY_W-1:0]        result_day,
   output logic [MONTH_W-1:0]      result_month,
   output logic [YEAR_W-1:0]       result_year
);

   logic [DOY_W-1:0]   acc_ff,  acc_in;
   logic [COUNT_W-1:0] x_ff,    x_in;
   logic [YEAR_W-1:0]  y_ff,    y_in;
   logic [YEAR_W-1:0]  r400_ff, r400_in;
   logic [MONTH_W-1:0] m_ff,    m_in;
   logic [MONTH_W-1:0] i_ff,    i_in;

   logic               leap;
   logic [DOY_W-1:0]   len_y;
   logic [DAY_W-1:0]   len_i;
   logic [DAY_W-1:0]   len_m;
   logic [DOY_W-1:0]   rem;
   logic [YEAR_W-1:0]  sub;
   logic [YEAR_W-1:0]  r400_inc;
   logic [MONTH_W-1:0] mon_clamped;

   // Leap rule on the year residue mod 400
   always_comb begin
      leap  = (r400_ff[1:0] == 2'd0) && (r400_ff != 14'd100) &&
              (r400_ff != 14'd200) && (r400_ff != 14'd300);
      len_y = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
      len_i = month_len(i_ff, leap);
      len_m = month_len(m_ff, leap);
      rem   = len_y - acc_ff;
      sub   = r400_sub(uword.arg);
      r400_inc = (r400_ff == CYCLE_400_LAST) ? '0 : r400_ff + 1'b1;
      if (start_month == '0) begin
         mon_clamped = MONTH_JAN;
      end else if (start_month > MONTH_DEC) begin
         mon_clamped = MONTH_DEC;
      end else begin
         mon_clamped = start_month;
      end
   end

   // Jump flags
   always_comb begin
      flags.i_lt_m   = i_ff < m_ff;
      flags.x_le_rem = x_ff <= COUNT_W'(rem);
      flags.x_gt_len = x_ff > COUNT_W'(len_y);
      flags.split_go = (m_ff < MONTH_DEC) && (acc_ff > DOY_W'(len_m));
   end

   // Register updates per operation
   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r400_in = r400_ff;
      m_in    = m_ff;
      i_in    = i_ff;
      case (uword.op)
         OP_LOAD: begin
            if (req_fire) begin
               acc_in  = DOY_W'(start_day);
               x_in    = days_to_add;
               y_in    = start_year;
               r400_in = start_year;
               m_in    = mon_clamped;
            end
         end
         OP_R400: begin
            if (r400_ff >= sub) begin
               r400_in = r400_ff - sub;
            end
         end
         OP_CLAMP: begin
            if (acc_ff == '0) begin
               acc_in = DOY_W'(1);
            end else if (acc_ff > DOY_W'(len_m)) begin
               acc_in = DOY_W'(len_m);
            end
            i_in = MONTH_JAN;
         end
         OP_DOY_ADD: begin
            if (flags.i_lt_m) begin
               acc_in = acc_ff + DOY_W'(len_i);
               i_in   = i_ff + 1'b1;
            end
         end
         OP_YEAR_FIRST: begin
            if (flags.x_le_rem) begin
               acc_in = acc_ff + DOY_W'(x_ff);
            end else begin
               x_in    = x_ff - COUNT_W'(rem);
               y_in    = y_ff + 1'b1;
               r400_in = r400_inc;
            end
         end
         OP_YEAR_STEP: begin
            if (flags.x_gt_len) begin
               x_in    = x_ff - COUNT_W'(len_y);
               y_in    = y_ff + 1'b1;
               r400_in = r400_inc;
            end else begin
               acc_in = DOY_W'(x_ff);
            end
         end
         OP_SPLIT_INIT: begin
            m_in = MONTH_JAN;
         end
         OP_SPLIT_STEP: begin
            if (flags.split_go) begin
               acc_in = acc_ff - DOY_W'(len_m);
               m_in   = m_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      r400_ff <= r400_in;
      m_ff    <= m_in;
      i_ff    <= i_in;
   end

   assign result_day   = acc_ff[DAY_W-1:0];
   assign result_month = m_ff;
   assign result_year  = y_ff;

   // A presented result has a day of 1 to 31 and a month of 1 to 12
   ap_out_date: assert property (@(posedge clock) disable iff (reset)
      uword.op == OP_OUT |-> (acc_ff != '0 && acc_ff <= DOY_W'(31) &&
                              m_ff != '0 && m_ff <= MONTH_DEC))
      else $error("result date out of range");

   // Year residue is reduced before years are stepped
   ap_r400_reduced: assert property (@(posedge clock) disable iff (reset)
      (uword.op == OP_YEAR_STEP || uword.op == OP_YEAR_FIRST) |->
         r400_ff <= CYCLE_400_LAST)
      else $error("year residue not reduced");

endmodule

`default_nettype wire

// ===== rtl/core/date_add_days_core.sv =====
// Top level of the date add-days core: sequencer, datapath and channel handshakes.
//
//  channel   dir  handshake        payload
//  req_chan  in   valid / ready    start_day, start_month, start_year, days_to_add
//  rsp_chan  out  valid / ready    result_day, result_month, result_year
//
// One item at a time. After the accepting edge the year is reduced mod 400, the day is
// clamped, the day of year is built month by month and the rest of the start year is
// consumed; when the count carries past it, whole years are stepped one per cycle in the
// year loop. The day of year is then split into month and day in at most 11 month steps
// before the result is presented.
// Synchronous active-high reset returns the sequencer to idle; no clearing pass.
// req_chan.ready is high only in the idle step; the result is held until taken.
`default_nettype none

module date_add_days_core import dad_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   dad_req_if.sink    req_chan,
   dad_rsp_if.source  rsp_chan
);

   ucode_type    uword;
   dp_flags_type flags;
   logic         req_fire;
   logic         rsp_fire;

   // Handshakes follow the current operation
   assign req_chan.ready = (uword.op == OP_LOAD);
   assign rsp_chan.valid = (uword.op == OP_OUT);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   dad_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .rsp_fire (rsp_fire),
      .flags    (flags),
      .uword    (uword)
   );

   dad_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .uword        (uword),
      .req_fire     (req_fire),
      .start_day    (req_chan.start_day),
      .start_month  (req_chan.start_month),
      .start_year   (req_chan.start_year),
      .days_to_add  (req_chan.days_to_add),
      .flags        (flags),
      .result_day   (rsp_chan.result_day),
      .result_month (rsp_chan.result_month),
      .result_year  (rsp_chan.result_year)
   );

endmodule

`default_nettype wire
